@@ design/ctbl_pkg.sv @@
// Shared types, micro-op codes and the control-store program for the cursor text buffer.
package ctbl_pkg;

  localparam int POOL_DEPTH_DEF = 1024;
  localparam int UPC_W          = 5;

  typedef enum logic [2:0] {
    CMD_LEFT       = 3'd0,
    CMD_RIGHT      = 3'd1,
    CMD_DELETE     = 3'd2,
    CMD_INSERT     = 3'd3,
    CMD_READ_FIRST = 3'd4,
    CMD_READ_NEXT  = 3'd5
  } ctbl_cmd_t;

  // Datapath micro-ops.
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_RD_CUR,    // link read at cursor
    ACT_RD_RD,     // link read at read position
    ACT_LATCH,     // capture next/prev links from read data
    ACT_CUR_PRV,
    ACT_CUR_NXT,
    ACT_UNLINK,
    ACT_INS_A,     // fill the fresh node
    ACT_INS_B,     // splice the fresh node in
    ACT_RD_HEAD,
    ACT_RD_ADV,
    ACT_TXT_RD     // character read at read position
  } ctbl_act_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_CUR_HEAD,
    COND_NXT_TAIL,
    COND_FULL,
    COND_RD_TAIL
  } ctbl_cond_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ZERO,
    EMIT_READ,
    EMIT_FULL
  } ctbl_emit_t;

  typedef struct packed {
    ctbl_act_t         act;
    ctbl_cond_t        cond;
    ctbl_emit_t        emit;
    logic [UPC_W-1:0]  target;
  } ctbl_ucw_t;

  typedef struct packed {
    logic cur_head;
    logic nxt_tail;
    logic full;
    logic rd_tail;
  } ctbl_stat_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] ch;
  } ctbl_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic       end_of_text;
    logic       pool_full;
  } ctbl_out_t;

  // Control store entry points.
  localparam logic [UPC_W-1:0] UA_ZERO  = 5'd0;
  localparam logic [UPC_W-1:0] UA_FULL  = 5'd1;
  localparam logic [UPC_W-1:0] UA_LEFT  = 5'd2;
  localparam logic [UPC_W-1:0] UA_RIGHT = 5'd5;
  localparam logic [UPC_W-1:0] UA_DEL   = 5'd9;
  localparam logic [UPC_W-1:0] UA_INS   = 5'd12;
  localparam logic [UPC_W-1:0] UA_RDF   = 5'd16;
  localparam logic [UPC_W-1:0] UA_TXT   = 5'd17;
  localparam logic [UPC_W-1:0] UA_RDN   = 5'd19;

  localparam ctbl_ucw_t UCW_IDLE = '{act: ACT_NOP, cond: COND_NONE, emit: EMIT_NONE,
                                     target: UA_ZERO};

  function automatic ctbl_ucw_t ctbl_uw(input ctbl_act_t a, input ctbl_cond_t c,
                                        input ctbl_emit_t e, input logic [UPC_W-1:0] t);
    ctbl_ucw_t w;
    w = '{act: a, cond: c, emit: e, target: t};
    return w;
  endfunction

  function automatic ctbl_ucw_t ctbl_rom(input logic [UPC_W-1:0] a);
    ctbl_ucw_t w;
    unique case (a)
      5'd0:  w = ctbl_uw(ACT_NOP,     COND_NONE,     EMIT_ZERO, UA_ZERO);
      5'd1:  w = ctbl_uw(ACT_NOP,     COND_NONE,     EMIT_FULL, UA_ZERO);
      // left
      5'd2:  w = ctbl_uw(ACT_RD_CUR,  COND_CUR_HEAD, EMIT_NONE, UA_ZERO);
      5'd3:  w = ctbl_uw(ACT_LATCH,   COND_NONE,     EMIT_NONE, UA_ZERO);
      5'd4:  w = ctbl_uw(ACT_CUR_PRV, COND_NONE,     EMIT_ZERO, UA_ZERO);
      // right
      5'd5:  w = ctbl_uw(ACT_RD_CUR,  COND_NONE,     EMIT_NONE, UA_ZERO);
      5'd6:  w = ctbl_uw(ACT_LATCH,   COND_NONE,     EMIT_NONE, UA_ZERO);
      5'd7:  w = ctbl_uw(ACT_NOP,     COND_NXT_TAIL, EMIT_NONE, UA_ZERO);
      5'd8:  w = ctbl_uw(ACT_CUR_NXT, COND_NONE,     EMIT_ZERO, UA_ZERO);
      // delete
      5'd9:  w = ctbl_uw(ACT_RD_CUR,  COND_CUR_HEAD, EMIT_NONE, UA_ZERO);
      5'd10: w = ctbl_uw(ACT_LATCH,   COND_NONE,     EMIT_NONE, UA_ZERO);
      5'd11: w = ctbl_uw(ACT_UNLINK,  COND_NONE,     EMIT_ZERO, UA_ZERO);
      // insert
      5'd12: w = ctbl_uw(ACT_RD_CUR,  COND_FULL,     EMIT_NONE, UA_FULL);
      5'd13: w = ctbl_uw(ACT_LATCH,   COND_NONE,     EMIT_NONE, UA_ZERO);
      5'd14: w = ctbl_uw(ACT_INS_A,   COND_NONE,     EMIT_NONE, UA_ZERO);
      5'd15: w = ctbl_uw(ACT_INS_B,   COND_NONE,     EMIT_ZERO, UA_ZERO);
      // read first, shared text fetch tail
      5'd16: w = ctbl_uw(ACT_RD_HEAD, COND_NONE,     EMIT_NONE, UA_ZERO);
      5'd17: w = ctbl_uw(ACT_TXT_RD,  COND_NONE,     EMIT_NONE, UA_ZERO);
      5'd18: w = ctbl_uw(ACT_NOP,     COND_NONE,     EMIT_READ, UA_ZERO);
      // read next
      5'd19: w = ctbl_uw(ACT_RD_RD,   COND_RD_TAIL,  EMIT_NONE, UA_TXT);
      5'd20: w = ctbl_uw(ACT_LATCH,   COND_NONE,     EMIT_NONE, UA_ZERO);
      5'd21: w = ctbl_uw(ACT_RD_ADV,  COND_ALWAYS,   EMIT_NONE, UA_TXT);
      default: w = ctbl_uw(ACT_NOP,   COND_NONE,     EMIT_ZERO, UA_ZERO);
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] ctbl_dispatch(input logic [2:0] cmd);
    logic [UPC_W-1:0] a;
    unique case (cmd)
      CMD_LEFT:       a = UA_LEFT;
      CMD_RIGHT:      a = UA_RIGHT;
      CMD_DELETE:     a = UA_DEL;
      CMD_INSERT:     a = UA_INS;
      CMD_READ_FIRST: a = UA_RDF;
      CMD_READ_NEXT:  a = UA_RDN;
      default:        a = UA_ZERO;
    endcase
    return a;
  endfunction

endpackage

@@ design/ctbl_useq.sv @@
// Microcode sequencer: step counter, control store fetch and conditional jumps.
module ctbl_useq
  import ctbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] cmd,
  input  ctbl_stat_t stat,
  output ctbl_ucw_t  ctl,
  output logic       busy
);

  logic             run_r, run_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ctbl_ucw_t        ucw;
  logic             hit;

  assign ucw  = ctbl_rom(upc_r);
  assign ctl  = run_r ? ucw : UCW_IDLE;
  assign busy = run_r;

  always_comb begin
    unique case (ucw.cond)
      COND_NONE:     hit = 1'b0;
      COND_ALWAYS:   hit = 1'b1;
      COND_CUR_HEAD: hit = stat.cur_head;
      COND_NXT_TAIL: hit = stat.nxt_tail;
      COND_FULL:     hit = stat.full;
      COND_RD_TAIL:  hit = stat.rd_tail;
      default:       hit = 1'b0;
    endcase
  end

  always_comb begin
    run_nxt = run_r;
    upc_nxt = upc_r;
    if (!run_r) begin
      if (start) begin
        run_nxt = 1'b1;
        upc_nxt = ctbl_dispatch(cmd);
      end
    end else if (ucw.emit != EMIT_NONE) begin
      run_nxt = 1'b0;
    end else if (hit) begin
      upc_nxt = ucw.target;
    end else begin
      upc_nxt = upc_r + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      upc_r <= UA_ZERO;
    end else begin
      run_r <= run_nxt;
      upc_r <= upc_nxt;
    end
  end

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !run_r) |=> run_r)
    else $error("accepted command did not start the sequencer");

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && ucw.emit != EMIT_NONE) |=> !run_r)
    else $error("sequencer kept running after its result step");

endmodule

@@ design/ctbl_dpath.sv @@
// Datapath: link and text memories, sentinel links, cursor, read position and result register.
module ctbl_dpath
  import ctbl_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_ch,
  input  ctbl_ucw_t  ctl,
  output ctbl_stat_t stat,
  output logic       out_strobe,
  output ctbl_out_t  out_item
);

  localparam int IW = $clog2(POOL_DEPTH + 2);
  localparam int AW = $clog2(POOL_DEPTH);
  localparam logic [IW-1:0] NODES = IW'(POOL_DEPTH);
  localparam logic [IW-1:0] HEAD  = IW'(POOL_DEPTH);
  localparam logic [IW-1:0] TAIL  = IW'(POOL_DEPTH + 1);

  logic [IW-1:0] aft_mem [POOL_DEPTH];
  logic [IW-1:0] bef_mem [POOL_DEPTH];
  logic [7:0]    txt_mem [POOL_DEPTH];

  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] rd_r, rd_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [IW-1:0] head_aft_r, head_aft_nxt;
  logic [IW-1:0] tail_bef_r, tail_bef_nxt;
  logic [IW-1:0] nxt_r, nxt_nxt;
  logic [IW-1:0] prv_r, prv_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          strobe_r, strobe_nxt;
  ctbl_out_t     out_r, out_nxt;

  logic [IW-1:0] aft_q, bef_q;
  logic [7:0]    txt_q;
  logic          ra_head_q, ra_tail_q;

  logic [IW-1:0] mem_ra;
  logic          aft_we, bef_we, txt_we;
  logic [IW-1:0] aft_wa, aft_wd, bef_wa, bef_wd;

  assign stat.cur_head = (cur_r == HEAD);
  assign stat.nxt_tail = (nxt_r == TAIL);
  assign stat.full     = (free_r >= NODES);
  assign stat.rd_tail  = (rd_r == TAIL);

  always_comb begin
    cur_nxt  = cur_r;
    rd_nxt   = rd_r;
    free_nxt = free_r;
    nxt_nxt  = nxt_r;
    prv_nxt  = prv_r;
    ch_nxt   = acc ? in_ch : ch_r;
    mem_ra   = cur_r;
    aft_we   = 1'b0;
    aft_wa   = cur_r;
    aft_wd   = nxt_r;
    bef_we   = 1'b0;
    bef_wa   = nxt_r;
    bef_wd   = prv_r;
    txt_we   = 1'b0;
    unique case (ctl.act)
      ACT_NOP:    ;
      ACT_RD_CUR: mem_ra = cur_r;
      ACT_RD_RD, ACT_TXT_RD: mem_ra = rd_r;
      ACT_LATCH: begin
        nxt_nxt = ra_head_q ? head_aft_r : aft_q;
        prv_nxt = ra_tail_q ? tail_bef_r : bef_q;
      end
      ACT_CUR_PRV: cur_nxt = prv_r;
      ACT_CUR_NXT: cur_nxt = nxt_r;
      ACT_UNLINK: begin
        aft_we  = 1'b1;
        aft_wa  = prv_r;
        aft_wd  = nxt_r;
        bef_we  = 1'b1;
        bef_wa  = nxt_r;
        bef_wd  = prv_r;
        cur_nxt = prv_r;
      end
      ACT_INS_A: begin
        aft_we = 1'b1;
        aft_wa = free_r;
        aft_wd = nxt_r;
        bef_we = 1'b1;
        bef_wa = free_r;
        bef_wd = cur_r;
        txt_we = 1'b1;
      end
      ACT_INS_B: begin
        bef_we   = 1'b1;
        bef_wa   = nxt_r;
        bef_wd   = free_r;
        aft_we   = 1'b1;
        aft_wa   = cur_r;
        aft_wd   = free_r;
        cur_nxt  = free_r;
        free_nxt = free_r + IW'(1);
      end
      ACT_RD_HEAD: rd_nxt = head_aft_r;
      ACT_RD_ADV:  rd_nxt = nxt_r;
      default: ;
    endcase
    // sentinel links live in flops
    head_aft_nxt = (aft_we && aft_wa == HEAD) ? aft_wd : head_aft_r;
    tail_bef_nxt = (bef_we && bef_wa == TAIL) ? bef_wd : tail_bef_r;
  end

  always_comb begin
    strobe_nxt = (ctl.emit != EMIT_NONE);
    out_nxt    = '0;
    unique case (ctl.emit)
      EMIT_NONE, EMIT_ZERO: ;
      EMIT_FULL: out_nxt.pool_full = 1'b1;
      EMIT_READ: begin
        if (rd_r == TAIL) begin
          out_nxt.end_of_text = 1'b1;
        end else if (rd_r != HEAD) begin
          out_nxt.out_char  = txt_q;
          out_nxt.out_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // node memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (aft_we && aft_wa < NODES) aft_mem[aft_wa[AW-1:0]] <= aft_wd;
    if (bef_we && bef_wa < NODES) bef_mem[bef_wa[AW-1:0]] <= bef_wd;
    if (txt_we) txt_mem[free_r[AW-1:0]] <= ch_r;
    aft_q     <= aft_mem[mem_ra[AW-1:0]];
    bef_q     <= bef_mem[mem_ra[AW-1:0]];
    txt_q     <= txt_mem[mem_ra[AW-1:0]];
    ra_head_q <= (mem_ra == HEAD);
    ra_tail_q <= (mem_ra == TAIL);
  end

  always_ff @(posedge clk) begin
    nxt_r <= nxt_nxt;
    prv_r <= prv_nxt;
    ch_r  <= ch_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= HEAD;
      rd_r       <= HEAD;
      free_r     <= '0;
      head_aft_r <= TAIL;
      tail_bef_r <= HEAD;
      strobe_r   <= 1'b0;
    end else begin
      cur_r      <= cur_nxt;
      rd_r       <= rd_nxt;
      free_r     <= free_nxt;
      head_aft_r <= head_aft_nxt;
      tail_bef_r <= tail_bef_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= NODES)
    else $error("node counter ran past the pool");

  a_cur_not_tail: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r != TAIL)
    else $error("cursor landed on the tail sentinel");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !(out_r.out_valid && out_r.end_of_text) && !(out_r.pool_full && out_r.out_valid))
    else $error("conflicting result flags");

endmodule

@@ design/cursor_text_buffer_list_top.sv @@
// Top level of the cursor text buffer: sequencer plus linked-list datapath.
//
//  channel  | ports                      | transfer
//  ---------+----------------------------+-----------------------------------------
//  command  | start, busy, in_item       | taken at a clock edge with start=1, busy=0
//  result   | out_strobe, out_item       | one cycle wide, always taken
//
// One command runs as a short microprogram, one step per cycle, after the
// accepting edge: left 3 (2 on head), right 4, delete 3 (2 on head), insert 4
// (2 when the pool is full), read first 3, read next 5 (3 on the tail),
// unknown codes 1 step.
// The result strobes in the cycle after the last step, and busy is already
// low then, so a new command can be taken in that cycle. Steps are set by
// the registered read of the link memories (one read port each) and by each
// memory taking one write per cycle.
// Reset (rst_n low, synchronous) empties the text: cursor and read position
// on head, head linked to tail, node counter zero; no clearing pass.
// The receiver cannot stall results; nothing backs up.
module cursor_text_buffer_list_top
  import ctbl_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ctbl_in_t  in_item,
  output logic      out_strobe,
  output ctbl_out_t out_item
);

  ctbl_ucw_t  ctl;
  ctbl_stat_t stat;
  logic       acc;

  // transaction taken on this edge
  assign acc = start && !busy;

  ctbl_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_item.cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  ctbl_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .in_ch      (in_item.ch),
    .ctl        (ctl),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the cursor text buffer: directed edits, random edit sessions.
`timescale 1ns / 100ps

module tb_top;
  import ctbl_pkg::*;

  localparam int POOL_DEPTH = POOL_DEPTH_DEF;
  localparam logic [10:0] HEAD_NODE = 11'(POOL_DEPTH);
  localparam logic [10:0] TAIL_NODE = 11'(POOL_DEPTH + 1);
  localparam int SLOTS      = POOL_DEPTH + 2;
  localparam int ITEMS      = 1200;
  localparam int MAX_CYCLES = 100000;
  localparam int IDLE_PCT   = 16;
  localparam int DRAIN_WAIT = 8;
  localparam int MAX_REPORTS = 100;

  // Command codes the block treats as no-ops.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // Scoreboard: mirrors the linked list, cursor and read position, and keeps
  // the results still owed by the block in order.
  class text_list_board;
    logic [7:0]  glyph     [POOL_DEPTH];
    logic [10:0] link_next [SLOTS];
    logic [10:0] link_prev [SLOTS];
    logic [10:0] cursor;
    logic [10:0] reader;
    logic [10:0] used;
    ctbl_out_t   pending[$];
    int          errors;

    function new();
      foreach (glyph[i]) glyph[i] = '0;
      foreach (link_next[i]) begin
        link_next[i] = '0;
        link_prev[i] = '0;
      end
      link_next[HEAD_NODE] = TAIL_NODE;
      link_prev[TAIL_NODE] = HEAD_NODE;
      cursor = HEAD_NODE;
      reader = HEAD_NODE;
      used   = '0;
      errors = 0;
    endfunction

    function logic [10:0] slot(input logic [10:0] idx);
      return (idx < SLOTS) ? idx : TAIL_NODE;
    endfunction

    // Result of landing the read position somewhere.
    function ctbl_out_t read_out();
      ctbl_out_t r;
      r = '0;
      reader = slot(reader);
      if (reader == TAIL_NODE) begin
        r.end_of_text = 1'b1;
      end else if (reader != HEAD_NODE) begin
        r.out_char  = glyph[reader[9:0]];
        r.out_valid = 1'b1;
      end
      return r;
    endfunction

    // Accepted command: update the list and queue the one result it owes.
    function void note_command(input ctbl_in_t it);
      ctbl_out_t   r;
      logic [10:0] c;
      logic [10:0] nx;
      logic [10:0] pv;
      r = '0;
      c = slot(cursor);
      case (it.cmd)
        CMD_LEFT: begin
          if (c != HEAD_NODE) cursor = slot(link_prev[c]);
        end
        CMD_RIGHT: begin
          nx = slot(link_next[c]);
          if (nx != TAIL_NODE) cursor = nx;
        end
        CMD_DELETE: begin
          if (c != HEAD_NODE) begin
            pv = slot(link_prev[c]);
            nx = slot(link_next[c]);
            link_next[pv] = nx;
            link_prev[nx] = pv;
            cursor = pv;
          end
        end
        CMD_INSERT: begin
          if (used >= 11'(POOL_DEPTH)) begin
            r.pool_full = 1'b1;
          end else begin
            nx = slot(link_next[c]);
            glyph[used[9:0]] = it.ch;
            link_next[used] = nx;
            link_prev[used] = c;
            link_prev[nx]   = used;
            link_next[c]    = used;
            cursor = used;
            used   = used + 11'd1;
          end
        end
        CMD_READ_FIRST: begin
          reader = slot(link_next[HEAD_NODE]);
          r = read_out();
        end
        CMD_READ_NEXT: begin
          reader = slot(reader);
          if (reader != TAIL_NODE) reader = slot(link_next[reader]);
          r = read_out();
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(input ctbl_out_t got);
      ctbl_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, got);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          if (got.out_char != want.out_char)
            $display("%0t: out_char expected %0d, actual %0d",
                     $time, want.out_char, got.out_char);
          if (got.out_valid != want.out_valid)
            $display("%0t: out_valid expected %0d, actual %0d",
                     $time, want.out_valid, got.out_valid);
          if (got.end_of_text != want.end_of_text)
            $display("%0t: end_of_text expected %0d, actual %0d",
                     $time, want.end_of_text, got.end_of_text);
          if (got.pool_full != want.pool_full)
            $display("%0t: pool_full expected %0d, actual %0d",
                     $time, want.pool_full, got.pool_full);
        end
      end
    endfunction
  endclass

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  ctbl_in_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  ctbl_out_t out_item;

  text_list_board sb;
  int cycles   = 0;
  int sent     = 0;   // commands accepted so far
  int ins_sent = 0;   // insert attempts; the pool is full once this reaches its depth

  cursor_text_buffer_list_top #(.POOL_DEPTH(POOL_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung block or a missing result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One process sees both channels at each edge, so a result is always checked
  // before the command taken at the same edge is queued. Values read here are
  // the ones the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_item);
      if (start && !busy) sb.note_command(in_item);
    end
  end

  // Drive one command and return right after the edge that takes it. The
  // sender idles now and then, except in one long steady stretch.
  task automatic issue(input logic [2:0] code, input logic [7:0] b);
    if (!(sent >= 500 && sent < 800) && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{cmd: code, ch: b};
    do @(posedge clk); while (busy);
    sent++;
    if (code == CMD_INSERT) ins_sent++;
  endtask

  // Hold the sender off until every owed result is in.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
    @(posedge clk);
  endtask

  // One random editing burst; mostly well-formed typing, moving and reading,
  // with some noise (including the spare codes) and the odd full drain.
  task automatic random_burst();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 55) begin
      len = $urandom_range(1, 24);
      repeat (len) issue(CMD_INSERT, 8'($urandom_range(255)));
    end else if (pick < 70) begin
      len = $urandom_range(1, 8);
      repeat (len)
        issue($urandom_range(1) ? CMD_RIGHT : CMD_LEFT, 8'($urandom_range(255)));
    end else if (pick < 78) begin
      len = $urandom_range(1, 4);
      repeat (len) issue(CMD_DELETE, 8'($urandom_range(255)));
    end else if (pick < 90) begin
      // read sweep; sometimes carry on from wherever the reader was left
      if ($urandom_range(99) < 70) issue(CMD_READ_FIRST, 8'($urandom_range(255)));
      len = $urandom_range(1, 24);
      repeat (len) issue(CMD_READ_NEXT, 8'($urandom_range(255)));
    end else if (pick < 97) begin
      issue(3'($urandom_range(7)), 8'($urandom_range(255)));
    end else begin
      drain();
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list corners, spare codes, byte extremes, reading past
    // the tail, and reading on from a node that was deleted under the reader.
    issue(CMD_READ_NEXT,  8'h00);   // reader still on head: acts as read first
    issue(CMD_READ_FIRST, 8'hFF);   // empty text: end flag
    issue(CMD_LEFT,       8'h00);   // left at the start
    issue(CMD_RIGHT,      8'h00);   // right at the end of empty text
    issue(CMD_DELETE,     8'h00);   // delete at the start
    issue(CMD_SPARE_LO,   8'hFF);
    issue(CMD_SPARE_HI,   8'hFF);
    issue(CMD_INSERT,     8'h00);
    issue(CMD_INSERT,     8'hFF);
    issue(CMD_INSERT,     8'h41);
    issue(CMD_LEFT,       8'h00);
    issue(CMD_LEFT,       8'h00);
    issue(CMD_LEFT,       8'h00);
    issue(CMD_LEFT,       8'h00);   // already on head
    issue(CMD_INSERT,     8'h80);   // insert at the very start
    issue(CMD_RIGHT,      8'h00);
    issue(CMD_RIGHT,      8'h00);
    issue(CMD_RIGHT,      8'h00);
    issue(CMD_RIGHT,      8'h00);   // already on the last character
    issue(CMD_READ_FIRST, 8'h00);
    issue(CMD_READ_NEXT,  8'h00);
    issue(CMD_LEFT,       8'h00);
    issue(CMD_LEFT,       8'h00);
    issue(CMD_DELETE,     8'h00);   // removes the node the reader sits on
    issue(CMD_READ_NEXT,  8'h00);   // follows the removed node's old link
    drain();

    // Random sessions: run until the pool has filled and a good number of
    // inserts have bounced off it.
    while (sent < ITEMS || ins_sent < POOL_DEPTH + 40)
      random_burst();

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ctbl_pkg.sv
design/ctbl_useq.sv
design/ctbl_dpath.sv
design/cursor_text_buffer_list_top.sv
test/tb_top.sv
